FILE: rtl/core/iirlp_pkg.sv
package iirlp_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_BITS      = 32;
    localparam int COEF_FRAC_BITS = 27;
    localparam int HIST_BITS      = 32;
    localparam int HIST_FRAC_BITS = 12;
    localparam int NUM_COEF       = 7;
    localparam int TAPS           = 4;
    localparam int CFG_ADDR_BITS  = $clog2(NUM_COEF);

    localparam int FF_BITS  = SAMPLE_BITS + COEF_BITS + 3 + HIST_FRAC_BITS;
    localparam int FB_BITS  = 2 * COEF_BITS + 3;
    localparam int ACC_BITS = ((FF_BITS > FB_BITS) ? FF_BITS : FB_BITS) + 2;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [COEF_BITS-1:0]   t_coef;
    typedef logic signed [HIST_BITS-1:0]   t_hist;
    typedef logic signed [ACC_BITS-1:0]    t_acc;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        COEF_B0,
        COEF_B1,
        COEF_B2,
        COEF_A1,
        COEF_A2,
        COEF_A3,
        COEF_A4
    } t_coef_idx;

    localparam t_coef COEF_RESET [NUM_COEF] = '{
        t_coef'(254154),
        t_coef'(-297999),
        t_coef'(454873),
        t_coef'(-451274481),
        t_coef'(574801948),
        t_coef'(-328130873),
        t_coef'(70752861)
    };

    typedef struct packed {
        t_hist   hist;
        t_sample filtered;
        logic    saturated;
    } t_rnd_res;

endpackage

FILE: rtl/core/iir_lowpass_4th_order_unit.sv
// Fourth-order direct form I low-pass IIR filter, one sample in, one sample out.
// Input channel: i_in_valid / o_in_stall with i_sample; a request is taken at a
// rising edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid / i_out_stall with o_filtered and o_saturated.
// Coefficients are written through i_cfg_we / i_cfg_addr / i_cfg_wdata, index 0..6
// for b0, b1, b2, a1, a2, a3, a4; index 7 is ignored. Write only while idle.
// A sample in the input register moves on to the output register once that
// is empty or read. Throughput is one sample per cycle while the receiver does
// not stall; the whole recursion (nine products, one exact sum, rounding and
// clipping) is combinational between them, so a new request may follow every cycle.
// Reset empties both registers, clears the sample and output histories and
// loads the default coefficients.
// When the receiver stalls, the result holds on the output; the input register
// holds its request and o_in_stall rises only once that register is also full.
module iir_lowpass_4th_order_unit import iirlp_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [COEF_BITS-1:0]     i_cfg_wdata,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_filtered,
    output logic                     o_saturated
);

    localparam t_acc ACC_ROUND = t_acc'((64'(1) << COEF_FRAC_BITS) >> 1);

    t_coef   r_coef [NUM_COEF];
    t_sample r_x_hist [TAPS];
    t_hist   r_y_hist [TAPS];

    logic    r_in_vld;
    t_sample r_x;
    logic    r_out_vld;
    t_sample r_filtered;
    logic    r_saturated;

    logic signed [SAMPLE_BITS+COEF_BITS-1:0] p_ff [TAPS+1];
    logic signed [2*COEF_BITS-1:0]           p_fb [TAPS];
    t_acc     ff_sum;
    t_acc     acc;
    t_rnd_res n_res;
    logic     adv;
    logic     in_take;

    assign p_ff[0] = r_coef[COEF_B0] * r_x;
    assign p_ff[1] = r_coef[COEF_B1] * r_x_hist[0];
    assign p_ff[2] = r_coef[COEF_B2] * r_x_hist[1];
    assign p_ff[3] = r_coef[COEF_B1] * r_x_hist[2];
    assign p_ff[4] = r_coef[COEF_B0] * r_x_hist[3];

    assign p_fb[0] = r_coef[COEF_A1] * r_y_hist[0];
    assign p_fb[1] = r_coef[COEF_A2] * r_y_hist[1];
    assign p_fb[2] = r_coef[COEF_A3] * r_y_hist[2];
    assign p_fb[3] = r_coef[COEF_A4] * r_y_hist[3];

    always_comb begin
        ff_sum = t_acc'(p_ff[0]) + t_acc'(p_ff[1]) + t_acc'(p_ff[2])
               + t_acc'(p_ff[3]) + t_acc'(p_ff[4]);
        acc    = (ff_sum <<< HIST_FRAC_BITS)
               - t_acc'(p_fb[0]) - t_acc'(p_fb[1])
               - t_acc'(p_fb[2]) - t_acc'(p_fb[3])
               + ACC_ROUND;
    end

    iirlp_round_sat u_round_sat (
        .i_acc (acc),
        .o_res (n_res)
    );

    assign adv        = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !adv;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= COEF_RESET;
        end else if (i_cfg_we && (i_cfg_addr inside {[COEF_B0:COEF_A4]})) begin
            r_coef[i_cfg_addr] <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_x <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TAPS; i++) begin
                r_x_hist[i] <= '0;
                r_y_hist[i] <= '0;
            end
        end else if (adv) begin
            for (int i = TAPS - 1; i > 0; i--) begin
                r_x_hist[i] <= r_x_hist[i-1];
                r_y_hist[i] <= r_y_hist[i-1];
            end
            r_x_hist[0] <= r_x;
            r_y_hist[0] <= n_res.hist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_filtered  <= n_res.filtered;
            r_saturated <= n_res.saturated;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_filtered  = r_filtered;
    assign o_saturated = r_saturated;

endmodule

FILE: rtl/core/iirlp_round_sat.sv
module iirlp_round_sat import iirlp_pkg::*; (
    input  t_acc     i_acc,
    output t_rnd_res o_res
);

    localparam int HIST_HALF = (1 << HIST_FRAC_BITS) >> 1;

    t_acc                          sh;
    logic [ACC_BITS-HIST_BITS:0]   top_h;
    logic                          sat_h;
    t_hist                         hist;
    logic signed [HIST_BITS:0]     hr;
    logic signed [HIST_BITS:0]     yi;
    logic [HIST_BITS-SAMPLE_BITS+1:0] top_o;
    logic                          sat_o;
    t_sample                       filtered;

    always_comb begin
        sh    = i_acc >>> COEF_FRAC_BITS;
        top_h = sh[ACC_BITS-1:HIST_BITS-1];
        sat_h = !((&top_h) || (~|top_h));
        if (sat_h) begin
            hist = i_acc[ACC_BITS-1] ? {1'b1, {(HIST_BITS-1){1'b0}}}
                                     : {1'b0, {(HIST_BITS-1){1'b1}}};
        end else begin
            hist = sh[HIST_BITS-1:0];
        end

        hr    = (HIST_BITS+1)'(hist) + (HIST_BITS+1)'(HIST_HALF);
        yi    = hr >>> HIST_FRAC_BITS;
        top_o = yi[HIST_BITS:SAMPLE_BITS-1];
        sat_o = !((&top_o) || (~|top_o));
        if (sat_o) begin
            filtered = yi[HIST_BITS] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                     : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end else begin
            filtered = yi[SAMPLE_BITS-1:0];
        end

        o_res.hist      = hist;
        o_res.filtered  = filtered;
        o_res.saturated = sat_h || sat_o;
    end

endmodule

FILE: test/tb_top.sv
module tb_top;
    import iirlp_pkg::*;

    typedef struct packed {
        t_sample filtered;
        logic    saturated;
    } t_filt_out;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_IDX_SPARE = CFG_ADDR_BITS'(NUM_COEF);
    localparam t_coef COEF_MAX = 32'sh7FFF_FFFF;
    localparam t_coef COEF_MIN = 32'sh8000_0000;
    localparam t_sample SAMPLE_MAX = 16'sh7FFF;
    localparam t_sample SAMPLE_MIN = 16'sh8000;
    localparam logic signed [127:0] HIST_HI = 128'sh7FFF_FFFF;
    localparam logic signed [127:0] HIST_LO = -128'sh8000_0000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_ADDR_BITS-1:0] i_cfg_addr = '0;
    logic [COEF_BITS-1:0] i_cfg_wdata = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [SAMPLE_BITS-1:0] i_sample = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [SAMPLE_BITS-1:0] o_filtered;
    logic o_saturated;

    t_coef coef [NUM_COEF] = COEF_RESET;
    t_sample past_x [TAPS] = '{default: '0};
    t_hist past_y [TAPS] = '{default: '0};

    t_sample pending_samples [$];
    t_filt_out expected_out [$];

    int n_taken = 0;
    int n_results = 0;
    int n_clipped = 0;
    int n_mismatch = 0;
    int n_coef_sets = 1;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit gapless = 1'b0;

    iir_lowpass_4th_order_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_filtered  (o_filtered),
        .o_saturated (o_saturated)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_filt_out filter_step(input t_sample x);
        logic signed [127:0] acc;
        t_hist hist;
        longint h64;
        longint y;
        t_filt_out r;
        acc = coef[COEF_B0] * x + coef[COEF_B1] * past_x[0] + coef[COEF_B2] * past_x[1]
            + coef[COEF_B1] * past_x[2] + coef[COEF_B0] * past_x[3];
        acc = (acc <<< HIST_FRAC_BITS)
            - coef[COEF_A1] * past_y[0] - coef[COEF_A2] * past_y[1]
            - coef[COEF_A3] * past_y[2] - coef[COEF_A4] * past_y[3]
            + (128'sd1 <<< (COEF_FRAC_BITS - 1));
        acc = acc >>> COEF_FRAC_BITS;
        r.saturated = 1'b0;
        if (acc > HIST_HI) begin
            hist = t_hist'(HIST_HI);
            r.saturated = 1'b1;
        end else if (acc < HIST_LO) begin
            hist = t_hist'(HIST_LO);
            r.saturated = 1'b1;
        end else begin
            hist = t_hist'(acc);
        end
        h64 = hist;
        y = (h64 + (64'sd1 <<< (HIST_FRAC_BITS - 1))) >>> HIST_FRAC_BITS;
        if (y > longint'(SAMPLE_MAX)) begin
            y = SAMPLE_MAX;
            r.saturated = 1'b1;
        end else if (y < longint'(SAMPLE_MIN)) begin
            y = SAMPLE_MIN;
            r.saturated = 1'b1;
        end
        r.filtered = t_sample'(y);
        for (int i = TAPS - 1; i > 0; i--) begin
            past_x[i] = past_x[i-1];
            past_y[i] = past_y[i-1];
        end
        past_x[0] = x;
        past_y[0] = hist;
        return r;
    endfunction

    function automatic t_sample pick_sample();
        case ($urandom_range(9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2, 3: return t_sample'(int'($urandom_range(127)) - 64);
            default: return t_sample'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int want_v, input int got_v);
        n_mismatch++;
        if (n_mismatch <= 10) begin
            $display("[%0t] result %0d %s: expected %0d, got %0d",
                     $time, n_results, what, want_v, got_v);
        end
    endtask

    task automatic check_output();
        t_filt_out want;
        if (expected_out.size() == 0) begin
            report_mismatch("unrequested result", 0, o_filtered);
            return;
        end
        want = expected_out.pop_front();
        n_results++;
        if (want.saturated) n_clipped++;
        if (o_filtered !== want.filtered) report_mismatch("filtered", want.filtered, o_filtered);
        if (o_saturated !== want.saturated)
            report_mismatch("saturated", want.saturated, o_saturated);
    endtask

    // Driver: take the accepted request into the predictor, then offer the next.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_out.push_back(filter_step(i_sample));
                n_taken++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_samples.size() != 0 && (gapless || $urandom_range(99) >= 19)) begin
                    i_in_valid <= 1'b1;
                    i_sample <= pending_samples.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Hold off the receiver once for a long stretch to back up the input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (!hold_done && n_results >= 200) begin
            hold_left <= 120;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: check results and drive the receiver stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) check_output();
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !gapless && ($urandom_range(99) < 19);
            end
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx, input t_coef val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        if (idx < NUM_COEF) coef[idx] = val;
    endtask

    task automatic load_coefs(input t_coef c [NUM_COEF]);
        for (int i = 0; i < NUM_COEF; i++) write_reg(CFG_ADDR_BITS'(i), c[i]);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_coef_sets++;
    endtask

    task automatic queue_random(input int n);
        repeat (n) pending_samples.push_back(pick_sample());
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || i_in_valid || expected_out.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        #8_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        t_coef set [NUM_COEF];
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default coefficients: impulse, steps, full-scale alternation
        pending_samples = '{16'sd0, SAMPLE_MAX, 16'sd0, 16'sd0, SAMPLE_MAX, SAMPLE_MAX,
                            SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN,
                            SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 16'sd1, -16'sd1};
        queue_random(320);
        wait_drained();

        // extreme coefficients; the spare index must not land anywhere
        write_reg(CFG_IDX_SPARE, COEF_MAX);
        set = '{COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX};
        load_coefs(set);
        pending_samples = '{SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 16'sd0, -16'sd1, SAMPLE_MAX};
        queue_random(100);
        wait_drained();

        set = '{COEF_MIN, COEF_MAX, COEF_MIN, '0, '0, '0, '0};
        load_coefs(set);
        queue_random(80);
        wait_drained();

        // gain of three on x[n] and x[n-4]: output clipping without history overflow
        set = '{t_coef'(3 <<< COEF_FRAC_BITS), '0, '0, '0, '0, '0, '0};
        load_coefs(set);
        queue_random(100);
        wait_drained();

        for (int k = 0; k < 6; k++) begin
            for (int i = 0; i < NUM_COEF; i++) begin
                if (k[0])
                    set[i] = t_coef'($urandom);
                else if (i < 3)
                    set[i] = t_coef'(int'($urandom_range(2**28)) - 2**27);
                else
                    set[i] = t_coef'(int'($urandom_range(2**26)) - 2**25);
            end
            load_coefs(set);
            queue_random(80);
            wait_drained();
        end

        // back to defaults, back-to-back traffic
        load_coefs(COEF_RESET);
        gapless = 1'b1;
        queue_random(300);
        wait_drained();
        gapless = 1'b0;
        repeat (5) @(posedge i_clk);

        $display("Ran %0d samples through %0d coefficient sets; %0d results clipped.",
                 n_taken, n_coef_sets, n_clipped);
        $display("%0d results checked, %0d mismatches.", n_results, n_mismatch);
        if (n_mismatch == 0 && expected_out.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
